### design/lbcs_pkg.sv
`timescale 1ns / 1ps
// Package for the LED blink code sequencer.
// Holds the register set struct, the phase codes and the state encoding; no dependencies.
package lbcs_pkg;

	localparam logic [1:0] REG_BLINK_COUNT  = 2'd0;
	localparam logic [1:0] REG_ON_OFF_TICKS = 2'd1;
	localparam logic [1:0] REG_PAUSE_TICKS  = 2'd2;

	localparam logic [7:0]  BLINK_COUNT_RST  = 8'd0;
	localparam logic [15:0] ON_OFF_TICKS_RST = 16'd200;
	localparam logic [15:0] PAUSE_TICKS_RST  = 16'd2000;

	localparam logic [1:0] PHASE_START    = 2'd0;
	localparam logic [1:0] PHASE_WAIT_OFF = 2'd1;
	localparam logic [1:0] PHASE_WAIT_ON  = 2'd2;
	localparam logic [1:0] PHASE_PAUSE    = 2'd3;

	typedef enum logic [3:0] {
		ST_START    = 4'b0001,
		ST_WAIT_OFF = 4'b0010,
		ST_WAIT_ON  = 4'b0100,
		ST_PAUSE    = 4'b1000
	} state_t;

	typedef struct packed {
		logic        restart;
		logic [7:0]  blink_count;
		logic [15:0] on_off_ticks;
		logic [15:0] pause_ticks;
	} cfg_t;

	function automatic logic [1:0] phase_code(input state_t st);
		logic [1:0] code;
		case (st)
			ST_START:    code = PHASE_START;
			ST_WAIT_OFF: code = PHASE_WAIT_OFF;
			ST_WAIT_ON:  code = PHASE_WAIT_ON;
			ST_PAUSE:    code = PHASE_PAUSE;
			default:     code = PHASE_START;
		endcase
		return code;
	endfunction

endpackage

### design/lbcs_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the LED blink code sequencer.
// Depends on lbcs_pkg for register indexes, reset values and the cfg_t struct.
module lbcs_cfg_regs import lbcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        cfg_ready,
	output cfg_t        cfg
);

	logic [7:0]  blink_count_q;
	logic [15:0] on_off_ticks_q;
	logic [15:0] pause_ticks_q;
	logic        wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_count_q  <= BLINK_COUNT_RST;
			on_off_ticks_q <= ON_OFF_TICKS_RST;
			pause_ticks_q  <= PAUSE_TICKS_RST;
		end else if (wr) begin
			case (cfg_index)
				REG_BLINK_COUNT:  blink_count_q  <= cfg_data[7:0];
				REG_ON_OFF_TICKS: on_off_ticks_q <= cfg_data;
				REG_PAUSE_TICKS:  pause_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.restart      = wr && (cfg_index == REG_BLINK_COUNT);
	assign cfg.blink_count  = blink_count_q;
	assign cfg.on_off_ticks = on_off_ticks_q;
	assign cfg.pause_ticks  = pause_ticks_q;

endmodule

### design/lbcs_step.sv
`timescale 1ns / 1ps
// Blink state machine with its countdown and the result register.
// Depends on lbcs_pkg for the state encoding, phase codes and cfg_t.
module lbcs_step import lbcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       led_on,
	output logic [1:0] phase,
	output logic [7:0] blinks_left
);

	state_t      state_q, state_d;
	logic [7:0]  remaining_q, remaining_d;
	logic [15:0] countdown_q, countdown_d, cd_ticked;
	logic        led_q, led_d;
	logic        out_valid_q;
	logic        led_on_q;
	logic [1:0]  phase_q;
	logic [7:0]  blinks_left_q;
	logic        accept;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cd_ticked   = (tick && countdown_q != 16'd0) ? countdown_q - 16'd1 : countdown_q;
		state_d     = state_q;
		remaining_d = remaining_q;
		countdown_d = cd_ticked;
		led_d       = led_q;
		case (state_q)
			ST_START: begin
				remaining_d = cfg.blink_count;
				if (cfg.blink_count != 8'd0) begin
					state_d = ST_WAIT_ON;
				end
			end
			ST_WAIT_OFF: begin
				if (cd_ticked == 16'd0) begin
					led_d       = 1'b0;
					countdown_d = cfg.on_off_ticks;
					state_d     = ST_WAIT_ON;
				end
			end
			ST_WAIT_ON: begin
				if (cd_ticked == 16'd0) begin
					if (remaining_q != 8'd0) begin
						remaining_d = remaining_q - 8'd1;
						countdown_d = cfg.on_off_ticks;
						led_d       = 1'b1;
						state_d     = ST_WAIT_OFF;
					end else begin
						countdown_d = cfg.pause_ticks;
						state_d     = ST_PAUSE;
					end
				end
			end
			ST_PAUSE: begin
				if (cd_ticked == 16'd0) begin
					state_d = ST_START;
				end
			end
			default: begin
				state_d = ST_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			remaining_q <= 8'd0;
			countdown_q <= 16'd0;
			led_q       <= 1'b0;
		end else if (cfg.restart) begin
			state_q <= ST_START;
			led_q   <= 1'b0;
		end else if (accept) begin
			state_q     <= state_d;
			remaining_q <= remaining_d;
			countdown_q <= countdown_d;
			led_q       <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			led_on_q      <= led_d;
			phase_q       <= phase_code(state_d);
			blinks_left_q <= remaining_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign led_on      = led_on_q;
	assign phase       = phase_q;
	assign blinks_left = blinks_left_q;

	// The LED is only lit while waiting to turn it off.
	assert property (@(posedge clk) disable iff (!arst_n)
		led_q |-> state_q == ST_WAIT_OFF)
		else $error("LED lit outside the wait-to-off phase");

	// Every accepted request leaves a result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request produced no result");

	// A step from start loads the blink count and leaves start when it is nonzero.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg.restart && state_q == ST_START && cfg.blink_count != 8'd0
		|=> state_q == ST_WAIT_ON && remaining_q == $past(cfg.blink_count))
		else $error("start phase did not load the blink group");

endmodule

### design/led_blink_code_sequencer.sv
`timescale 1ns / 1ps
// LED blink code sequencer top level; depends on lbcs_pkg, lbcs_cfg_regs and lbcs_step.
// An accepted request has its result in the output register in the next cycle.
// Throughput: one request per cycle while in_stall is low; the single state update per step sets that figure.
// Reset: arst_n clears the state to start with the LED dark and loads the register defaults.
// Configuration writes are always ready; a blink count write restarts the sequence.
module led_blink_code_sequencer import lbcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        led_on,
	output logic [1:0]  phase,
	output logic [7:0]  blinks_left
);

	cfg_t cfg;

	lbcs_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	lbcs_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.tick        (tick),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_on      (led_on),
		.phase       (phase),
		.blinks_left (blinks_left)
	);

endmodule
